[hdl/gdcm_pkg.sv]
// ----------------------------------------------------------------------------
// gdcm_pkg
// Shared widths, reset values, codes and types of the gamepad drive command
// mapper.
// ----------------------------------------------------------------------------
package gdcm_pkg;

   // field widths
   localparam int unsigned AXIS_WIDTH      = 16;
   localparam int unsigned SPEED_WIDTH     = 10;
   localparam int unsigned SCALE_WIDTH     = 7;
   localparam int unsigned PATTERN_WIDTH   = 4;
   localparam int unsigned LINEAR_WIDTH    = 27;
   localparam int unsigned ANGULAR_WIDTH   = 23;
   localparam int unsigned COLOUR_WIDTH    = 3;
   localparam int unsigned BUTTON_COUNT    = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 10;

   // number of buzzer patterns, 2 to 15
   localparam int unsigned BUZZER_PATTERNS_DEFAULT = 8;

   // reset values
   localparam logic [SPEED_WIDTH-1:0] SLOW_SPEED_RESET   = 10'd100;
   localparam logic [SPEED_WIDTH-1:0] NORMAL_SPEED_RESET = 10'd200;
   localparam logic [SPEED_WIDTH-1:0] FAST_SPEED_RESET   = 10'd350;
   localparam logic [SCALE_WIDTH-1:0] TURN_MIN_RESET     = 7'd8;
   localparam logic [SCALE_WIDTH-1:0] TURN_MAX_RESET     = 7'd90;
   localparam logic [SCALE_WIDTH-1:0] TURN_SCALE_RESET   = 7'd90;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SLOW_SPEED   = 3'd0,
      CSR_NORMAL_SPEED = 3'd1,
      CSR_FAST_SPEED   = 3'd2,
      CSR_TURN_MIN     = 3'd3,
      CSR_TURN_MAX     = 3'd4
   } csr_index_type;

   // speed modes
   typedef enum logic [1:0] {
      MODE_SLOW   = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_FAST   = 2'd2
   } speed_mode_type;

   // sign of the vertical d-pad axis seen on the last beat
   typedef enum logic [1:0] {
      VSIGN_ZERO = 2'd0,
      VSIGN_POS  = 2'd1,
      VSIGN_NEG  = 2'd2
   } vsign_type;

   // configuration registers
   typedef struct packed {
      logic [SPEED_WIDTH-1:0] slow_speed;
      logic [SPEED_WIDTH-1:0] normal_speed;
      logic [SPEED_WIDTH-1:0] fast_speed;
      logic [SCALE_WIDTH-1:0] turn_scale_min;
      logic [SCALE_WIDTH-1:0] turn_scale_max;
   } cfg_type;

   // one sample after the state update, ahead of the multipliers
   typedef struct packed {
      logic [SPEED_WIDTH-1:0]  speed;
      logic [AXIS_WIDTH:0]     trigger_diff;
      logic [SCALE_WIDTH-1:0]  turn_scale;
      logic [AXIS_WIDTH-1:0]   stick;
      logic                    play;
      logic [PATTERN_WIDTH-1:0] pattern;
      logic                    led_update;
      logic [COLOUR_WIDTH-1:0] rgb;
      speed_mode_type          mode;
   } sample_type;

   // colour table, {red, green, blue}
   function automatic logic [COLOUR_WIDTH-1:0] colour_rgb(
      input logic [COLOUR_WIDTH-1:0] idx
   );
      logic [COLOUR_WIDTH-1:0] rgb;
      case (idx)
         3'd0:    rgb = 3'b100;
         3'd1:    rgb = 3'b010;
         3'd2:    rgb = 3'b001;
         3'd3:    rgb = 3'b110;
         3'd4:    rgb = 3'b101;
         3'd5:    rgb = 3'b011;
         3'd6:    rgb = 3'b111;
         default: rgb = 3'b000;
      endcase
      return rgb;
   endfunction

endpackage

[hdl/gdcm_csr.sv]
// ----------------------------------------------------------------------------
// gdcm_csr
// Configuration registers: speed per mode and turn scale limits.
// ----------------------------------------------------------------------------
module gdcm_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [gdcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gdcm_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output gdcm_pkg::cfg_type                      cfg
);

   gdcm_pkg::cfg_type cfg_ff;
   gdcm_pkg::cfg_type cfg_in;

   // write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (gdcm_pkg::csr_index_type'(csr_index))
            gdcm_pkg::CSR_SLOW_SPEED: begin
               cfg_in.slow_speed = csr_write_data[gdcm_pkg::SPEED_WIDTH-1:0];
            end
            gdcm_pkg::CSR_NORMAL_SPEED: begin
               cfg_in.normal_speed = csr_write_data[gdcm_pkg::SPEED_WIDTH-1:0];
            end
            gdcm_pkg::CSR_FAST_SPEED: begin
               cfg_in.fast_speed = csr_write_data[gdcm_pkg::SPEED_WIDTH-1:0];
            end
            gdcm_pkg::CSR_TURN_MIN: begin
               cfg_in.turn_scale_min = csr_write_data[gdcm_pkg::SCALE_WIDTH-1:0];
            end
            gdcm_pkg::CSR_TURN_MAX: begin
               cfg_in.turn_scale_max = csr_write_data[gdcm_pkg::SCALE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_speed     <= gdcm_pkg::SLOW_SPEED_RESET;
         cfg_ff.normal_speed   <= gdcm_pkg::NORMAL_SPEED_RESET;
         cfg_ff.fast_speed     <= gdcm_pkg::FAST_SPEED_RESET;
         cfg_ff.turn_scale_min <= gdcm_pkg::TURN_MIN_RESET;
         cfg_ff.turn_scale_max <= gdcm_pkg::TURN_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/gdcm_state.sv]
// ----------------------------------------------------------------------------
// gdcm_state
// Controller state: button and d-pad edge detection, buzzer pattern, colour,
// speed mode and turn scale. Produces the updated sample for the accepted beat.
// ----------------------------------------------------------------------------
module gdcm_state #(
   parameter int unsigned BUZZER_PATTERNS = gdcm_pkg::BUZZER_PATTERNS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 horn_key,
   input  logic                                 color_key,
   input  logic                                 pattern_up_key,
   input  logic                                 pattern_down_key,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0] pad_vert,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0] pad_horiz,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0] fwd_trigger,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0] rev_trigger,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0] turn_stick,
   input  gdcm_pkg::cfg_type                    cfg,
   output gdcm_pkg::sample_type                 sample
);

   localparam int unsigned PAT_WIDTH = $clog2(BUZZER_PATTERNS + 1);
   localparam logic [PAT_WIDTH-1:0] PAT_ONE = PAT_WIDTH'(1);
   localparam logic [PAT_WIDTH-1:0] PAT_MAX = PAT_WIDTH'(BUZZER_PATTERNS);

   localparam int unsigned SW = gdcm_pkg::SCALE_WIDTH;
   localparam int unsigned AW = gdcm_pkg::AXIS_WIDTH;

   logic [gdcm_pkg::BUTTON_COUNT-1:0] prev_ff, levels, rise;
   logic [PAT_WIDTH-1:0]              pattern_ff, pattern_in, pattern_up;
   logic [gdcm_pkg::COLOUR_WIDTH-1:0] colour_ff, colour_in;
   gdcm_pkg::speed_mode_type          mode_ff, mode_in;
   gdcm_pkg::vsign_type               vsign_ff, vsign_in;
   logic [SW-1:0]                     scale_ff, scale_in, scale_inc, scale_dec;
   logic [SW:0]                       inc_sum;
   logic                              dv_pos, dv_neg, dh_pos, dh_neg;

   // button rising edges, bit order Y, B, L1, L2
   assign levels = {pattern_down_key, pattern_up_key, color_key, horn_key};
   assign rise   = levels & ~prev_ff;

   // buzzer pattern: L1 steps up, then L2 steps down, both wrap
   assign pattern_up = rise[2] ? ((pattern_ff >= PAT_MAX) ? PAT_ONE : pattern_ff + PAT_ONE)
                               : pattern_ff;
   assign pattern_in = rise[3] ? ((pattern_up <= PAT_ONE) ? PAT_MAX : pattern_up - PAT_ONE)
                               : pattern_up;

   // colour advances on a B edge
   assign colour_in = colour_ff + gdcm_pkg::COLOUR_WIDTH'(rise[1]);

   // axis signs
   assign dv_neg = pad_vert[AW-1];
   assign dv_pos = !pad_vert[AW-1] && (pad_vert != '0);
   assign dh_neg = pad_horiz[AW-1];
   assign dh_pos = !pad_horiz[AW-1] && (pad_horiz != '0);

   // speed mode steps on a vertical d-pad edge, no wrap
   always_comb begin
      mode_in = mode_ff;
      if (dv_pos && (vsign_ff != gdcm_pkg::VSIGN_POS) && (mode_ff != gdcm_pkg::MODE_FAST)) begin
         mode_in = (mode_ff == gdcm_pkg::MODE_SLOW) ? gdcm_pkg::MODE_NORMAL
                                                    : gdcm_pkg::MODE_FAST;
      end else if (dv_neg && (vsign_ff != gdcm_pkg::VSIGN_NEG) &&
                   (mode_ff != gdcm_pkg::MODE_SLOW)) begin
         mode_in = (mode_ff == gdcm_pkg::MODE_FAST) ? gdcm_pkg::MODE_NORMAL
                                                    : gdcm_pkg::MODE_SLOW;
      end
   end

   always_comb begin
      if (dv_pos) begin
         vsign_in = gdcm_pkg::VSIGN_POS;
      end else if (dv_neg) begin
         vsign_in = gdcm_pkg::VSIGN_NEG;
      end else begin
         vsign_in = gdcm_pkg::VSIGN_ZERO;
      end
   end

   // turn scale: one step per beat while held, clamped to the limits
   assign inc_sum   = {1'b0, scale_ff} + (SW + 1)'(1);
   assign scale_inc = (inc_sum < {1'b0, cfg.turn_scale_max}) ? inc_sum[SW-1:0]
                                                             : cfg.turn_scale_max;
   assign scale_dec = ((scale_ff != '0) && ((scale_ff - SW'(1)) > cfg.turn_scale_min))
                      ? scale_ff - SW'(1) : cfg.turn_scale_min;

   always_comb begin
      if (dh_pos) begin
         scale_in = scale_inc;
      end else if (dh_neg) begin
         scale_in = scale_dec;
      end else begin
         scale_in = scale_ff;
      end
   end

   // sample handed to the multiply stage
   always_comb begin
      case (mode_in)
         gdcm_pkg::MODE_SLOW:   sample.speed = cfg.slow_speed;
         gdcm_pkg::MODE_NORMAL: sample.speed = cfg.normal_speed;
         default:               sample.speed = cfg.fast_speed;
      endcase
      sample.trigger_diff = {fwd_trigger[AW-1], fwd_trigger}
                            - {rev_trigger[AW-1], rev_trigger};
      sample.turn_scale   = scale_in;
      sample.stick        = turn_stick;
      sample.play         = rise[0];
      sample.pattern      = rise[0] ? gdcm_pkg::PATTERN_WIDTH'(pattern_ff)
                                    : gdcm_pkg::PATTERN_WIDTH'(pattern_in);
      sample.led_update   = rise[1];
      sample.rgb          = gdcm_pkg::colour_rgb(colour_in);
      sample.mode         = mode_in;
   end

   // state registers, updated once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         vsign_ff   <= gdcm_pkg::VSIGN_ZERO;
         mode_ff    <= gdcm_pkg::MODE_NORMAL;
         scale_ff   <= gdcm_pkg::TURN_SCALE_RESET;
         pattern_ff <= PAT_ONE;
         colour_ff  <= '0;
      end else if (accept) begin
         prev_ff    <= levels;
         vsign_ff   <= vsign_in;
         mode_ff    <= mode_in;
         scale_ff   <= scale_in;
         pattern_ff <= pattern_in;
         colour_ff  <= colour_in;
      end
   end

   // state only moves on an accepted beat
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(mode_ff) && $stable(scale_ff) && $stable(pattern_ff)
                  && $stable(colour_ff))
      else $error("controller state changed without a beat");

   // pattern stays within 1..BUZZER_PATTERNS
   a_pattern_range: assert property (@(posedge clock) disable iff (reset)
      (pattern_ff >= PAT_ONE) && (pattern_ff <= PAT_MAX))
      else $error("buzzer pattern out of range");

   // speed mode never goes from slow straight to fast on one beat
   a_mode_step: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_ff == gdcm_pkg::MODE_SLOW) |=> (mode_ff != gdcm_pkg::MODE_FAST))
      else $error("speed mode skipped a step");

endmodule

[hdl/gdcm_mult.sv]
// ----------------------------------------------------------------------------
// gdcm_mult
// Result stage: linear and angular velocity multiplies into the result
// register.
// ----------------------------------------------------------------------------
module gdcm_mult (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  logic                                       sample_valid,
   input  gdcm_pkg::sample_type                       sample,
   output logic                                       rsp_valid,
   output logic signed [gdcm_pkg::LINEAR_WIDTH-1:0]   rsp_linear_velocity,
   output logic signed [gdcm_pkg::ANGULAR_WIDTH-1:0]  rsp_angular_velocity,
   output logic                                       rsp_buzzer_play,
   output logic [gdcm_pkg::PATTERN_WIDTH-1:0]         rsp_buzzer_pattern,
   output logic                                       rsp_led_update,
   output logic                                       rsp_led_red,
   output logic                                       rsp_led_green,
   output logic                                       rsp_led_blue,
   output logic [1:0]                                 rsp_speed_mode,
   output logic [gdcm_pkg::SCALE_WIDTH-1:0]           rsp_turn_scale
);

   localparam int unsigned LIN_FULL = gdcm_pkg::SPEED_WIDTH + 1 + gdcm_pkg::AXIS_WIDTH + 1;
   localparam int unsigned ANG_FULL = gdcm_pkg::SCALE_WIDTH + 1 + gdcm_pkg::AXIS_WIDTH;

   logic signed [LIN_FULL-1:0] lin_full;
   logic signed [ANG_FULL-1:0] ang_full;
   logic                       valid_ff;
   gdcm_pkg::sample_type       out_ff;
   logic [gdcm_pkg::LINEAR_WIDTH-1:0]  lin_ff;
   logic [gdcm_pkg::ANGULAR_WIDTH-1:0] ang_ff;

   // speed and scale are unsigned, so widen with a zero
   assign lin_full = $signed({1'b0, sample.speed}) * $signed(sample.trigger_diff);
   assign ang_full = $signed({1'b0, sample.turn_scale}) * $signed(sample.stick);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= sample_valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= sample;
         lin_ff <= lin_full[gdcm_pkg::LINEAR_WIDTH-1:0];
         ang_ff <= ang_full[gdcm_pkg::ANGULAR_WIDTH-1:0];
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_linear_velocity  = $signed(lin_ff);
   assign rsp_angular_velocity = $signed(ang_ff);
   assign rsp_buzzer_play      = out_ff.play;
   assign rsp_buzzer_pattern   = out_ff.pattern;
   assign rsp_led_update       = out_ff.led_update;
   assign rsp_led_red          = out_ff.rgb[2];
   assign rsp_led_green        = out_ff.rgb[1];
   assign rsp_led_blue         = out_ff.rgb[0];
   assign rsp_speed_mode       = out_ff.mode;
   assign rsp_turn_scale       = out_ff.turn_scale;

endmodule

[hdl/gamepad_drive_command_mapper.sv]
// ----------------------------------------------------------------------------
// gamepad_drive_command_mapper
// Maps one gamepad sample to one drive command.
// ----------------------------------------------------------------------------
// Every accepted sample gives exactly one command, in order, and the block
// takes one sample per clock while req_stall is low. Edge detection and the
// state update (pattern, colour, speed mode, turn scale) run from the request
// ports into a sample register at the accepting edge; the two multiplies (mode
// speed by trigger difference, turn scale by stick) then run from the sample
// register into the result register, whose load sets rsp_valid. The two
// registers form a pipeline that moves whenever the result is empty or taken;
// while a result waits, one more sample is taken into the sample register and
// the input stalls only once both are full. Configuration writes take effect
// from the next accepted sample on and are meant to be made while no command
// is in flight.
module gamepad_drive_command_mapper #(
   parameter int unsigned BUZZER_PATTERNS = gdcm_pkg::BUZZER_PATTERNS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // sample channel
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_horn_key,
   input  logic                                       req_color_key,
   input  logic                                       req_pattern_up_key,
   input  logic                                       req_pattern_down_key,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0]     req_pad_vert,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0]     req_pad_horiz,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0]     req_fwd_trigger,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0]     req_rev_trigger,
   input  logic signed [gdcm_pkg::AXIS_WIDTH-1:0]     req_turn_stick,
   // command channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [gdcm_pkg::LINEAR_WIDTH-1:0]   rsp_linear_velocity,
   output logic signed [gdcm_pkg::ANGULAR_WIDTH-1:0]  rsp_angular_velocity,
   output logic                                       rsp_buzzer_play,
   output logic [gdcm_pkg::PATTERN_WIDTH-1:0]         rsp_buzzer_pattern,
   output logic                                       rsp_led_update,
   output logic                                       rsp_led_red,
   output logic                                       rsp_led_green,
   output logic                                       rsp_led_blue,
   output logic [1:0]                                 rsp_speed_mode,
   output logic [gdcm_pkg::SCALE_WIDTH-1:0]           rsp_turn_scale,
   // configuration
   input  logic                                       csr_write_enable,
   input  logic [gdcm_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [gdcm_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data
);

   gdcm_pkg::cfg_type    cfg;
   gdcm_pkg::sample_type sample_in, s1_ff;
   logic                 s1_valid_ff;
   logic                 advance, s1_load, accept;

   // pipeline control
   assign advance   = !rsp_valid || !rsp_stall;
   assign s1_load   = !s1_valid_ff || advance;
   assign req_stall = !s1_load;
   assign accept    = req_valid && s1_load;

   gdcm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   gdcm_state #(
      .BUZZER_PATTERNS (BUZZER_PATTERNS)
   ) u_state (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .horn_key         (req_horn_key),
      .color_key        (req_color_key),
      .pattern_up_key   (req_pattern_up_key),
      .pattern_down_key (req_pattern_down_key),
      .pad_vert         (req_pad_vert),
      .pad_horiz        (req_pad_horiz),
      .fwd_trigger      (req_fwd_trigger),
      .rev_trigger      (req_rev_trigger),
      .turn_stick       (req_turn_stick),
      .cfg              (cfg),
      .sample           (sample_in)
   );

   // sample register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= sample_in;
      end
   end

   gdcm_mult u_mult (
      .clock                (clock),
      .reset                (reset),
      .load                 (advance),
      .sample_valid         (s1_valid_ff),
      .sample               (s1_ff),
      .rsp_valid            (rsp_valid),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_buzzer_play      (rsp_buzzer_play),
      .rsp_buzzer_pattern   (rsp_buzzer_pattern),
      .rsp_led_update       (rsp_led_update),
      .rsp_led_red          (rsp_led_red),
      .rsp_led_green        (rsp_led_green),
      .rsp_led_blue         (rsp_led_blue),
      .rsp_speed_mode       (rsp_speed_mode),
      .rsp_turn_scale       (rsp_turn_scale)
   );

   // input only stalls when both stages are full and the result is held
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // a held sample beat is neither lost nor changed
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
      else $error("sample stage lost a held beat");

endmodule

[dv/gamepad_drive_command_mapper_test.sv]
// ----------------------------------------------------------------------------
// gamepad_drive_command_mapper_test
// Self-checking bench for the gamepad drive command mapper: a table of
// directed samples, then bursts of random samples under several register
// settings. An in-bench model of the mapper state predicts every command, and
// each command taken from the block is compared field by field.
// ----------------------------------------------------------------------------
module gamepad_drive_command_mapper_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW     = gdcm_pkg::AXIS_WIDTH;
   localparam int LIN_W  = gdcm_pkg::LINEAR_WIDTH;
   localparam int ANG_W  = gdcm_pkg::ANGULAR_WIDTH;
   localparam int PAT_W  = gdcm_pkg::PATTERN_WIDTH;
   localparam int SCL_W  = gdcm_pkg::SCALE_WIDTH;
   localparam int COL_W  = gdcm_pkg::COLOUR_WIDTH;
   localparam int IDX_W  = gdcm_pkg::CSR_INDEX_WIDTH;
   localparam int DATA_W = gdcm_pkg::CSR_DATA_WIDTH;

   localparam int NUM_PATTERNS     = gdcm_pkg::BUZZER_PATTERNS_DEFAULT;
   localparam int PHASES           = 7;
   localparam int PHASE_ITEMS      = 275;
   localparam int SETTLE_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 300;

   // button levels packed as {l2, l1, b, y}
   localparam logic [3:0] BTN_NONE = 4'b0000;
   localparam logic [3:0] BTN_Y    = 4'b0001;
   localparam logic [3:0] BTN_B    = 4'b0010;
   localparam logic [3:0] BTN_L1   = 4'b0100;
   localparam logic [3:0] BTN_L2   = 4'b1000;

   // {red, green, blue} per colour index
   localparam logic [COL_W-1:0] COLOUR_TABLE [8] = '{
      3'b100, 3'b010, 3'b001, 3'b110, 3'b101, 3'b011, 3'b111, 3'b000
   };

   typedef struct {
      logic                  y, b, l1, l2;
      logic signed [AW-1:0]  dv, dh, rt, lt, stick;
   } stim_type;

   typedef struct {
      logic signed [LIN_W-1:0]  linear;
      logic signed [ANG_W-1:0]  angular;
      logic                     play;
      logic [PAT_W-1:0]         pattern;
      logic                     led_update, red, green, blue;
      gdcm_pkg::speed_mode_type mode;
      logic [SCL_W-1:0]         scale;
   } command_type;

   typedef struct {
      stim_type    s;
      bit          typed;
      command_type want;
   } row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_horn_key, req_color_key;
   logic                       req_pattern_up_key, req_pattern_down_key;
   logic signed [AW-1:0]       req_pad_vert, req_pad_horiz;
   logic signed [AW-1:0]       req_fwd_trigger, req_rev_trigger;
   logic signed [AW-1:0]       req_turn_stick;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [LIN_W-1:0]    rsp_linear_velocity;
   logic signed [ANG_W-1:0]    rsp_angular_velocity;
   logic                       rsp_buzzer_play;
   logic [PAT_W-1:0]           rsp_buzzer_pattern;
   logic                       rsp_led_update;
   logic                       rsp_led_red, rsp_led_green, rsp_led_blue;
   logic [1:0]                 rsp_speed_mode;
   logic [SCL_W-1:0]           rsp_turn_scale;
   logic                       csr_write_enable;
   logic [IDX_W-1:0]           csr_index;
   logic [DATA_W-1:0]          csr_write_data;

   // predicted mapper state and registers
   gdcm_pkg::cfg_type        cfg;
   logic [3:0]               prev_levels;
   gdcm_pkg::vsign_type      prev_vsign;
   gdcm_pkg::speed_mode_type cur_mode;
   int                       cur_scale;
   int                       cur_pattern;
   logic [COL_W-1:0]         cur_colour;

   command_type pending_commands[$];
   row_type     directed_rows[$];
   int          burst_left;
   int          mismatch_count;
   int          commands_checked;
   int          rcv_cycles;
   int          stall_style;
   int          hold_left;
   int          idle_cycles;

   gamepad_drive_command_mapper #(
      .BUZZER_PATTERNS(NUM_PATTERNS)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_horn_key         (req_horn_key),
      .req_color_key        (req_color_key),
      .req_pattern_up_key   (req_pattern_up_key),
      .req_pattern_down_key (req_pattern_down_key),
      .req_pad_vert         (req_pad_vert),
      .req_pad_horiz        (req_pad_horiz),
      .req_fwd_trigger      (req_fwd_trigger),
      .req_rev_trigger      (req_rev_trigger),
      .req_turn_stick       (req_turn_stick),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_buzzer_play      (rsp_buzzer_play),
      .rsp_buzzer_pattern   (rsp_buzzer_pattern),
      .rsp_led_update       (rsp_led_update),
      .rsp_led_red          (rsp_led_red),
      .rsp_led_green        (rsp_led_green),
      .rsp_led_blue         (rsp_led_blue),
      .rsp_speed_mode       (rsp_speed_mode),
      .rsp_turn_scale       (rsp_turn_scale),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #1 clock = ~clock;

   // next command from one sample; advances the predicted state
   function automatic command_type predict_command(input stim_type s);
      command_type                     c;
      logic [3:0]                      levels;
      logic [3:0]                      rise;
      int                              played;
      int                              step;
      int                              diff;
      logic [gdcm_pkg::SPEED_WIDTH-1:0] speed;
      levels = {s.l2, s.l1, s.b, s.y};
      rise   = levels & ~prev_levels;
      played = cur_pattern;
      // pattern steps up, then down, wrapping in 1..NUM_PATTERNS
      if (rise[2]) cur_pattern = (cur_pattern >= NUM_PATTERNS) ? 1 : cur_pattern + 1;
      if (rise[3]) cur_pattern = (cur_pattern <= 1) ? NUM_PATTERNS : cur_pattern - 1;
      if (rise[1]) cur_colour = cur_colour + 3'd1;
      // speed mode moves on a change of vertical sign, no wrap
      if (s.dv > 0 && prev_vsign != gdcm_pkg::VSIGN_POS && cur_mode != gdcm_pkg::MODE_FAST)
         cur_mode = (cur_mode == gdcm_pkg::MODE_SLOW) ? gdcm_pkg::MODE_NORMAL
                                                      : gdcm_pkg::MODE_FAST;
      else if (s.dv < 0 && prev_vsign != gdcm_pkg::VSIGN_NEG &&
               cur_mode != gdcm_pkg::MODE_SLOW)
         cur_mode = (cur_mode == gdcm_pkg::MODE_FAST) ? gdcm_pkg::MODE_NORMAL
                                                      : gdcm_pkg::MODE_SLOW;
      prev_vsign = (s.dv > 0) ? gdcm_pkg::VSIGN_POS
                              : ((s.dv < 0) ? gdcm_pkg::VSIGN_NEG : gdcm_pkg::VSIGN_ZERO);
      // turn scale follows the held horizontal pad
      if (s.dh > 0) begin
         step = cur_scale + 1;
         cur_scale = (step < int'(cfg.turn_scale_max)) ? step : int'(cfg.turn_scale_max);
      end else if (s.dh < 0) begin
         step = cur_scale - 1;
         cur_scale = (step > int'(cfg.turn_scale_min)) ? step : int'(cfg.turn_scale_min);
      end
      if (cur_scale < 0) cur_scale = 0;
      if (cur_scale > 127) cur_scale = 127;
      case (cur_mode)
         gdcm_pkg::MODE_SLOW:   speed = cfg.slow_speed;
         gdcm_pkg::MODE_NORMAL: speed = cfg.normal_speed;
         default:               speed = cfg.fast_speed;
      endcase
      diff = int'(s.rt) - int'(s.lt);
      c.linear     = LIN_W'(int'(speed) * diff);
      c.angular    = ANG_W'(cur_scale * int'(s.stick));
      c.play       = rise[0];
      c.pattern    = PAT_W'(rise[0] ? played : cur_pattern);
      c.led_update = rise[1];
      {c.red, c.green, c.blue} = COLOUR_TABLE[cur_colour];
      c.mode       = cur_mode;
      c.scale      = SCL_W'(cur_scale);
      prev_levels  = levels;
      return c;
   endfunction

   // axis held in one direction, magnitude free
   function automatic logic signed [AW-1:0] held_axis(input int dir);
      if (dir > 0)
         return ($urandom_range(0, 3) == 0) ? 16'sh7FFF : AW'($urandom_range(1, 32767));
      if (dir < 0)
         return ($urandom_range(0, 3) == 0) ? 16'sh8000 :
                AW'(-int'($urandom_range(1, 32768)));
      return '0;
   endfunction

   // analog axis, extremes weighted up
   function automatic logic signed [AW-1:0] free_axis();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return 16'sh0001;
         4:       return 16'shFFFF;
         default: return AW'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: command %0d: %s", commands_checked, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   task automatic add_row(input logic [3:0] btn, input int dv, input int dh,
                          input int rt, input int lt, input int st);
      row_type r;
      {r.s.l2, r.s.l1, r.s.b, r.s.y} = btn;
      r.s.dv    = AW'(dv);
      r.s.dh    = AW'(dh);
      r.s.rt    = AW'(rt);
      r.s.lt    = AW'(lt);
      r.s.stick = AW'(st);
      r.typed   = 1'b0;
      directed_rows.push_back(r);
   endtask

   task automatic add_typed_row(input logic [3:0] btn, input int dv, input int dh,
                                input int rt, input int lt, input int st,
                                input command_type want);
      add_row(btn, dv, dh, rt, lt, st);
      directed_rows[directed_rows.size() - 1].typed = 1'b1;
      directed_rows[directed_rows.size() - 1].want  = want;
   endtask

   // one sample beat; sender may idle between bursts of random length
   task automatic send_sample(input row_type r);
      command_type predicted;
      int          gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_horn_key         <= r.s.y;
      req_color_key        <= r.s.b;
      req_pattern_up_key   <= r.s.l1;
      req_pattern_down_key <= r.s.l2;
      req_pad_vert         <= r.s.dv;
      req_pad_horiz        <= r.s.dh;
      req_fwd_trigger      <= r.s.rt;
      req_rev_trigger      <= r.s.lt;
      req_turn_stick       <= r.s.stick;
      req_valid            <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_command(r.s);
      pending_commands.push_back(r.typed ? r.want : predicted);
   endtask

   // stop sending until every command is back and the pipe is empty
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         gdcm_pkg::CSR_SLOW_SPEED:   cfg.slow_speed     = data;
         gdcm_pkg::CSR_NORMAL_SPEED: cfg.normal_speed   = data;
         gdcm_pkg::CSR_FAST_SPEED:   cfg.fast_speed     = data;
         gdcm_pkg::CSR_TURN_MIN:     cfg.turn_scale_min = data[SCL_W-1:0];
         gdcm_pkg::CSR_TURN_MAX:     cfg.turn_scale_max = data[SCL_W-1:0];
         default:                    ;
      endcase
   endtask

   task automatic apply_setting(input logic [DATA_W-1:0] slow,
                                input logic [DATA_W-1:0] normal,
                                input logic [DATA_W-1:0] fast,
                                input logic [DATA_W-1:0] tmin,
                                input logic [DATA_W-1:0] tmax);
      write_csr(gdcm_pkg::CSR_SLOW_SPEED, slow);
      write_csr(gdcm_pkg::CSR_NORMAL_SPEED, normal);
      write_csr(gdcm_pkg::CSR_FAST_SPEED, fast);
      write_csr(gdcm_pkg::CSR_TURN_MIN, tmin);
      write_csr(gdcm_pkg::CSR_TURN_MAX, tmax);
   endtask

   // mostly sticky button levels and pad directions, some pure noise
   task automatic run_random(input int count);
      row_type    r;
      logic [3:0] held;
      int         vdir;
      int         hdir;
      held = '0;
      vdir = 0;
      hdir = 0;
      r.typed = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_commands();
         if ($urandom_range(0, 9) == 0) begin
            {r.s.l2, r.s.l1, r.s.b, r.s.y} = 4'($urandom);
            r.s.dv = AW'($urandom);
            r.s.dh = AW'($urandom);
         end else begin
            held = held ^ (4'($urandom) & 4'($urandom));
            if ($urandom_range(0, 3) == 0) vdir = int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 7) == 0) hdir = int'($urandom_range(0, 2)) - 1;
            {r.s.l2, r.s.l1, r.s.b, r.s.y} = held;
            r.s.dv = held_axis(vdir);
            r.s.dh = held_axis(hdir);
         end
         r.s.rt    = free_axis();
         r.s.lt    = free_axis();
         r.s.stick = free_axis();
         send_sample(r);
      end
   endtask

   // command side: stall pattern, long hold-offs, compare each beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_commands.size() == 0) begin
               report_mismatch("command with none expected");
            end else begin
               command_type want;
               want = pending_commands.pop_front();
               check_field("linear_velocity", rsp_linear_velocity, want.linear);
               check_field("angular_velocity", rsp_angular_velocity, want.angular);
               check_field("buzzer_play", rsp_buzzer_play, want.play);
               check_field("buzzer_pattern", rsp_buzzer_pattern, want.pattern);
               check_field("led_update", rsp_led_update, want.led_update);
               check_field("led_red", rsp_led_red, want.red);
               check_field("led_green", rsp_led_green, want.green);
               check_field("led_blue", rsp_led_blue, want.blue);
               check_field("speed_mode", rsp_speed_mode, want.mode);
               check_field("turn_scale", rsp_turn_scale, want.scale);
            end
            commands_checked++;
            if (commands_checked == 400 || commands_checked == 1200)
               hold_left = LONG_HOLD_CYCLES;
         end
         rcv_cycles++;
         if (rcv_cycles % 50 == 0) stall_style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (rcv_cycles % 2 == 1);
            endcase
         end
      end
   end

   // watchdog on beats of either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      command_type fixed;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_horn_key         = 1'b0;
      req_color_key        = 1'b0;
      req_pattern_up_key   = 1'b0;
      req_pattern_down_key = 1'b0;
      req_pad_vert         = '0;
      req_pad_horiz        = '0;
      req_fwd_trigger      = '0;
      req_rev_trigger      = '0;
      req_turn_stick       = '0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      burst_left           = 0;
      mismatch_count       = 0;
      commands_checked     = 0;
      rcv_cycles           = 0;
      stall_style          = 0;
      hold_left            = 0;
      idle_cycles          = 0;

      cfg = '{gdcm_pkg::SLOW_SPEED_RESET, gdcm_pkg::NORMAL_SPEED_RESET,
              gdcm_pkg::FAST_SPEED_RESET, gdcm_pkg::TURN_MIN_RESET,
              gdcm_pkg::TURN_MAX_RESET};
      prev_levels = '0;
      prev_vsign  = gdcm_pkg::VSIGN_ZERO;
      cur_mode    = gdcm_pkg::MODE_NORMAL;
      cur_scale   = int'(gdcm_pkg::TURN_SCALE_RESET);
      cur_pattern = 1;
      cur_colour  = '0;

      // directed table; typed rows are read straight off the reset state
      fixed = '{27'sd0, 23'sd0, 1'b0, 4'd1, 1'b0, 1'b1, 1'b0, 1'b0,
                gdcm_pkg::MODE_NORMAL, 7'd90};
      add_typed_row(BTN_NONE, 0, 0, 0, 0, 0, fixed);
      fixed.linear  = 27'sd13107000;
      fixed.angular = -23'sd2949120;
      add_typed_row(BTN_NONE, 0, 0, 32767, -32768, -32768, fixed);
      fixed.linear  = -27'sd13107000;
      fixed.angular = 23'sd2949030;
      add_typed_row(BTN_NONE, 0, 0, -32768, 32767, 32767, fixed);
      fixed.linear  = 27'sd0;
      fixed.angular = 23'sd0;
      fixed.play    = 1'b1;
      add_typed_row(BTN_Y, 0, 0, 0, 0, 0, fixed);
      // Y held, L1 pressed; then Y and L1 together shows the old pattern
      add_row(BTN_Y | BTN_L1, 0, 0, 1000, -1000, -1);
      add_row(BTN_NONE, 0, 0, 0, 0, 0);
      add_row(BTN_Y | BTN_L1, 0, 0, -1, 1, 1);
      add_row(BTN_NONE, 0, 0, 0, 0, 0);
      // all four at once: up then down, play and colour step
      add_row(BTN_Y | BTN_B | BTN_L1 | BTN_L2, 0, 0, 12345, -321, -20000);
      add_row(BTN_NONE, 0, 0, 7, 7, 7);
      // pattern down to the bottom wrap, colour steps, held B, top wrap
      add_row(BTN_L2, 0, 0, 500, 0, 300);
      add_row(BTN_B, 0, 0, 0, 500, -300);
      add_row(BTN_L2, 0, 0, 32767, 32767, 1);
      add_row(BTN_B, 0, 0, -32768, -32768, -1);
      add_row(BTN_L2 | BTN_B, 0, 0, 100, 200, 16384);
      add_row(BTN_L1, 0, 0, -200, 100, -16384);
      // speed mode edges and the ends, turn scale at its top and stepping down
      add_row(BTN_NONE, 32767, 0, 32767, 0, 32767);
      add_row(BTN_NONE, 1, 0, -32768, 0, 100);
      add_row(BTN_NONE, 0, 32767, 1, 0, -100);
      add_row(BTN_NONE, 5, 0, 0, -1, 32767);
      add_row(BTN_NONE, -1, -32768, 32767, -32768, -32768);
      add_row(BTN_NONE, 0, 0, 32767, -32768, 32767);
      add_row(BTN_NONE, -32768, -1, -32768, 32767, -32768);
      add_row(BTN_NONE, 1, 0, 32767, -32768, -32768);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_sample(directed_rows[i]);
      drain_commands();

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_setting(10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd127);
            1: apply_setting(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
            2: apply_setting(10'd512, 10'd1, 10'd1023, 10'd100, 10'd20);
            3: apply_setting(10'd7, 10'd300, 10'd900, 10'd127, 10'd127);
            4, 5: apply_setting(DATA_W'($urandom), DATA_W'($urandom),
                                DATA_W'($urandom), DATA_W'($urandom),
                                DATA_W'($urandom));
            default: apply_setting(gdcm_pkg::SLOW_SPEED_RESET,
                                   gdcm_pkg::NORMAL_SPEED_RESET,
                                   gdcm_pkg::FAST_SPEED_RESET,
                                   DATA_W'(gdcm_pkg::TURN_MIN_RESET),
                                   DATA_W'(gdcm_pkg::TURN_MAX_RESET));
         endcase
         // indexes past the last register must be ignored
         if (p == 4) begin
            for (int k = int'(gdcm_pkg::CSR_TURN_MAX) + 1; k < 2 ** IDX_W; k++)
               write_csr(IDX_W'(k), DATA_W'($urandom));
         end
         run_random(PHASE_ITEMS);
         drain_commands();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/gdcm_pkg.sv
hdl/gdcm_csr.sv
hdl/gdcm_state.sv
hdl/gdcm_mult.sv
hdl/gamepad_drive_command_mapper.sv
dv/gamepad_drive_command_mapper_test.sv
